### rtl/core/iav_pkg.sv
// Shared types and constants for the image average/normalize block.
// No dependencies; compile first.
package iav_pkg;

    localparam int PIX_IN_W   = 10;   // input pixel width, also stored average width
    localparam int PIX_OUT_W  = 8;    // normalized pixel width
    localparam int STATUS_W   = 2;
    localparam int DIV_STEPS  = PIX_OUT_W;             // one quotient bit per step
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
    localparam int PROD_W     = 2 * PIX_OUT_W;         // avg * 255 fits here

    localparam logic [PIX_IN_W-1:0] FULL_SCALE = PIX_IN_W'(255);

    // Request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_DIVIDE,
        S_EMIT
    } iav_state_t;

endpackage

### rtl/core/iav_if.sv
// Request and result channel interfaces (valid/ready handshake).
// Depends on iav_pkg.
interface iav_req_if;
    import iav_pkg::*;
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [PIX_IN_W-1:0] pixel_a;
    logic [PIX_IN_W-1:0] pixel_b;

    modport source (output valid, req_type, pixel_a, pixel_b, input ready);
    modport sink   (input valid, req_type, pixel_a, pixel_b, output ready);
endinterface

interface iav_rsp_if;
    import iav_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [PIX_OUT_W-1:0] pixel_out;
    logic [STATUS_W-1:0]  status;
    logic                 last;

    modport source (output valid, pixel_out, status, last, input ready);
    modport sink   (input valid, pixel_out, status, last, output ready);
endinterface

### rtl/core/image_average_normalize.sv
// Timing: a load takes effect at its accepting edge and returns nothing. An ok drain
// reads the store at its accepting edge, then passes through the fetch state (divider
// setup), 8 divider steps and the emit state. A drain with an error status skips the
// divider and goes from the fetch state straight to the emit state.
// Throughput: one load per cycle while idle; a drain runs through the FSM before the next
// request is taken, and the bit-serial divider produces one quotient bit per cycle. A new
// request is taken only while idle; a result held on rsp stalls the emit state and
// delays the return to idle by the stall.
// Reset (rst_n, async, active low) clears peak, counts, FSM and the result slot; the
// pixel store itself is not cleared and needs no clearing pass.
// Depends on iav_pkg and iav_if.
module image_average_normalize #(
    parameter int MAX_PIXELS = 4096
) (
    input  logic      clk,
    input  logic      rst_n,
    iav_req_if.sink   req,
    iav_rsp_if.source rsp
);
    import iav_pkg::*;

    localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
    localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    iav_state_t            state_reg, state_next;
    logic [PIX_IN_W-1:0]   peak_reg, peak_next;
    logic [CNT_W-1:0]      loaded_reg, loaded_next;
    logic [CNT_W-1:0]      drain_idx_reg, drain_idx_next;
    logic [STATUS_W-1:0]   status_reg, status_next;     // status of the drain in flight
    logic [PIX_OUT_W-1:0]  rem_reg, rem_next;           // divider partial remainder
    logic [PIX_OUT_W-1:0]  shift_reg, shift_next;       // dividend bits out, quotient bits in
    logic [DIV_CNT_W-1:0]  step_reg, step_next;

    // Result slot: parts the divider from the consumer
    logic                  out_valid_reg, out_valid_next;
    logic [PIX_OUT_W-1:0]  out_pix_reg, out_pix_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic                  out_last_reg, out_last_next;

    // Pixel store
    logic [PIX_IN_W-1:0]   store_mem [MAX_PIXELS];
    logic [PIX_IN_W-1:0]   rd_data_reg;

    logic                  accept;
    logic                  load_acc;
    logic                  store_full;
    logic [PIX_IN_W:0]     pair_sum;
    logic [PIX_IN_W-1:0]   pair_avg;
    logic [PROD_W-1:0]     scaled;
    logic [PIX_OUT_W:0]    trial;
    logic [PIX_OUT_W:0]    trial_diff;
    logic [CNT_W-1:0]      drain_inc;
    logic                  slot_free;
    logic                  is_last;

    assign req.ready  = (state_reg == S_IDLE);
    assign accept     = req.valid && req.ready;
    assign store_full = (loaded_reg == CNT_W'(MAX_PIXELS));
    assign load_acc   = accept && (req.req_type == REQ_LOAD) && !store_full;

    assign pair_sum = {1'b0, req.pixel_a} + {1'b0, req.pixel_b};
    assign pair_avg = pair_sum[PIX_IN_W:1];

    // avg * 255 = (avg << 8) - avg; only used when peak <= 255, so avg fits 8 bits
    assign scaled = {rd_data_reg[PIX_OUT_W-1:0], PIX_OUT_W'(0)}
                  - {PIX_OUT_W'(0), rd_data_reg[PIX_OUT_W-1:0]};

    // one restoring-division step; quotient fits 8 bits since avg <= peak
    assign trial      = {rem_reg, shift_reg[PIX_OUT_W-1]};
    assign trial_diff = trial - {1'b0, peak_reg[PIX_OUT_W-1:0]};

    assign drain_inc = drain_idx_reg + 1'b1;
    assign is_last   = (drain_inc == loaded_reg);
    assign slot_free = !out_valid_reg || rsp.ready;

    // ------------------------------------------------------------------
    // Store: one write port (loads), one registered read port (drain)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (load_acc)
        begin
            store_mem[loaded_reg[ADDR_W-1:0]] <= pair_avg;
        end
        rd_data_reg <= store_mem[drain_idx_reg[ADDR_W-1:0]];
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            peak_reg      <= '0;
            loaded_reg    <= '0;
            drain_idx_reg <= '0;
            status_reg    <= ST_OK;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            peak_reg      <= peak_next;
            loaded_reg    <= loaded_next;
            drain_idx_reg <= drain_idx_next;
            status_reg    <= status_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        rem_reg        <= rem_next;
        shift_reg      <= shift_next;
        out_pix_reg    <= out_pix_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    // ------------------------------------------------------------------
    // Next state and outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        peak_next       = peak_reg;
        loaded_next     = loaded_reg;
        drain_idx_next  = drain_idx_reg;
        status_next     = status_reg;
        step_next       = step_reg;
        rem_next        = rem_reg;
        shift_next      = shift_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_pix_next    = out_pix_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (load_acc)
                begin
                    loaded_next = loaded_reg + 1'b1;
                    if (pair_avg > peak_reg)
                    begin
                        peak_next = pair_avg;
                    end
                end
                else if (accept && (req.req_type == REQ_DRAIN))
                begin
                    // status is fixed here; peak cannot move until the result leaves
                    if ((loaded_reg == '0) || (drain_idx_reg >= loaded_reg))
                        status_next = ST_EMPTY;
                    else if (peak_reg > FULL_SCALE)
                        status_next = ST_OVER;
                    else if (peak_reg == '0)
                        status_next = ST_ZERO;
                    else
                        status_next = ST_OK;
                    state_next = S_FETCH;
                end
            end

            S_FETCH:
            begin
                // rd_data_reg now holds the entry at drain_idx_reg
                rem_next   = scaled[PROD_W-1:PIX_OUT_W];
                shift_next = scaled[PIX_OUT_W-1:0];
                step_next  = DIV_CNT_W'(DIV_STEPS);
                state_next = (status_reg == ST_OK) ? S_DIVIDE : S_EMIT;
            end

            S_DIVIDE:
            begin
                if (!trial_diff[PIX_OUT_W])
                begin
                    rem_next   = trial_diff[PIX_OUT_W-1:0];
                    shift_next = {shift_reg[PIX_OUT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next   = trial[PIX_OUT_W-1:0];
                    shift_next = {shift_reg[PIX_OUT_W-2:0], 1'b0};
                end
                step_next = step_reg - 1'b1;
                if (step_reg == DIV_CNT_W'(1))
                begin
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_pix_next    = (status_reg == ST_OK) ? shift_reg : '0;
                    out_last_next   = 1'b0;
                    if (status_reg != ST_EMPTY)
                    begin
                        out_last_next = is_last;
                        if (is_last)
                        begin
                            loaded_next    = '0;
                            drain_idx_next = '0;
                            peak_next      = '0;
                        end
                        else
                        begin
                            drain_idx_next = drain_inc;
                        end
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.pixel_out = out_pix_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.last      = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        drain_idx_reg <= loaded_reg)
        else $error("drain index passed loaded count");

    a_bad_pix_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != ST_OK)) |-> (rsp.pixel_out == '0))
        else $error("nonzero pixel with error status");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && slot_free && status_reg != ST_EMPTY && is_last)
        |=> (loaded_reg == '0 && peak_reg == '0 && drain_idx_reg == '0))
        else $error("final drain did not clear the image");

    a_empty_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_EMPTY) |-> !rsp.last)
        else $error("empty result marked last");

endmodule
